### rtl/hhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhp_pkg: shared types and constants of the HTTP request head parser
// Parse-state codes, status and byte-class codes, character constants,
// the parser context and the per-byte result.
// ----------------------------------------------------------------------------
package hhp_pkg;

  // parse states
  localparam logic [4:0] S_REQ_START   = 5'd0;
  localparam logic [4:0] S_METHOD      = 5'd1;
  localparam logic [4:0] S_WS_URI      = 5'd2;
  localparam logic [4:0] S_URI         = 5'd3;
  localparam logic [4:0] S_WS_PROTO    = 5'd4;
  localparam logic [4:0] S_P_H         = 5'd5;
  localparam logic [4:0] S_P_HT        = 5'd6;
  localparam logic [4:0] S_P_HTT       = 5'd7;
  localparam logic [4:0] S_P_HTTP      = 5'd8;
  localparam logic [4:0] S_P_SLASH     = 5'd9;
  localparam logic [4:0] S_P_MAJOR     = 5'd10;
  localparam logic [4:0] S_P_DOT       = 5'd11;
  localparam logic [4:0] S_LINE_CR     = 5'd12;
  localparam logic [4:0] S_LINE_LF     = 5'd13;
  localparam logic [4:0] S_HDR_START   = 5'd14;
  localparam logic [4:0] S_HDR_END_LF  = 5'd15;
  localparam logic [4:0] S_HDR_NAME    = 5'd16;
  localparam logic [4:0] S_HDR_PRE_VAL = 5'd17;
  localparam logic [4:0] S_HDR_VALUE   = 5'd18;
  localparam logic [4:0] S_HDR_LINE_LF = 5'd19;
  localparam logic [4:0] S_HDR_DONE    = 5'd20;
  localparam logic [4:0] S_ERROR       = 5'd21;

  // status codes
  localparam logic [2:0] STAT_BUSY     = 3'd0;
  localparam logic [2:0] STAT_LINE     = 3'd1;
  localparam logic [2:0] STAT_HDRS     = 3'd2;
  localparam logic [2:0] STAT_ERROR    = 3'd3;
  localparam logic [2:0] STAT_IGNORED  = 3'd4;

  // byte classes
  localparam logic [2:0] CLS_DELIM     = 3'd0;
  localparam logic [2:0] CLS_METHOD    = 3'd1;
  localparam logic [2:0] CLS_URI       = 3'd2;
  localparam logic [2:0] CLS_NAME      = 3'd3;
  localparam logic [2:0] CLS_VALUE     = 3'd4;

  // method / version codes
  localparam logic [1:0] METH_GET      = 2'd1;
  localparam logic [1:0] METH_POST     = 2'd2;
  localparam logic [1:0] VER_1_0       = 2'd1;
  localparam logic [1:0] VER_1_1       = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // configuration
  localparam logic        REG_MAX_FIELD_LEN   = 1'b0;
  localparam logic [15:0] MAX_FIELD_LEN_RESET = 16'd1024;

  typedef struct packed {
    logic        new_req;
    logic [7:0]  data;
  } item_t;

  // parser context; all-zero is the cleared state (S_REQ_START is zero)
  typedef struct packed {
    logic [4:0]       state;
    logic [3:0][7:0]  mchars;
    logic [2:0]       mcount;
    logic [1:0]       mseen;
    logic [1:0]       vseen;
    logic [15:0]      uri_cnt;
    logic [15:0]      name_cnt;
    logic [15:0]      value_cnt;
    logic [15:0]      trim_cnt;
  } ctx_t;

  localparam ctx_t CTX_CLEAR = '0;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  cls;
    logic [7:0]  data;
    logic [1:0]  method;
    logic [1:0]  version;
    logic [15:0] uri_len;
    logic        commit;
    logic [15:0] name_len;
    logic [15:0] value_len;
  } res_t;

  function automatic logic is_name_char(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                     CH_USCORE, CH_DASH, CH_DOT};
  endfunction

endpackage
`default_nettype wire

### rtl/hhp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhp_cfg: configuration register port
// APB-style slave holding the field length limit.
// ----------------------------------------------------------------------------
module hhp_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      max_len_o
);

  logic [15:0] max_len_r;
  logic [15:0] max_len_nxt;
  logic        sel_max;

  assign sel_max = (paddr[2] == hhp_pkg::REG_MAX_FIELD_LEN);

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite && sel_max) begin
      max_len_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= hhp_pkg::MAX_FIELD_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign pready    = 1'b1;
  assign prdata    = sel_max ? {16'd0, max_len_r} : 32'd0;
  assign max_len_o = max_len_r;

endmodule
`default_nettype wire

### rtl/hhp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhp_in_stage: input register
// Captures one byte transaction; refills in the cycle the held one moves on.
// ----------------------------------------------------------------------------
module hhp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hhp_pkg::item_t item_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output hhp_pkg::item_t     item_o
);

  logic           valid_r;
  logic           valid_nxt;
  hhp_pkg::item_t item_r;
  logic           accept;

  assign in_stall = valid_r && !take_i;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_i;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule
`default_nettype wire

### rtl/hhp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhp_step: one parse step
// Next context and result for one request byte.
// ----------------------------------------------------------------------------
module hhp_step (
  input  wire hhp_pkg::ctx_t ctx_i,
  input  wire hhp_pkg::item_t item_i,
  input  wire logic [15:0]   max_len_i,
  output hhp_pkg::ctx_t      ctx_o,
  output hhp_pkg::res_t      res_o
);

  hhp_pkg::ctx_t cur;
  hhp_pkg::ctx_t nxt;
  logic [7:0]    c;
  logic [2:0]    status;
  logic [2:0]    cls;
  logic          fail;
  logic          line_done;
  logic          commit;
  logic [15:0]   nlen;
  logic [15:0]   vlen;
  logic          blank;

  assign c     = item_i.data;
  assign blank = (c == hhp_pkg::CH_SP) || (c == hhp_pkg::CH_TAB);

  always_comb begin
    cur       = item_i.new_req ? hhp_pkg::CTX_CLEAR : ctx_i;
    nxt       = cur;
    status    = hhp_pkg::STAT_BUSY;
    cls       = hhp_pkg::CLS_DELIM;
    fail      = 1'b0;
    line_done = 1'b0;
    commit    = 1'b0;

    case (cur.state)
      hhp_pkg::S_REQ_START: begin
        if (c == hhp_pkg::CH_G || c == hhp_pkg::CH_P) begin
          nxt.mchars[0] = c;
          nxt.mcount    = 3'd1;
          cls           = hhp_pkg::CLS_METHOD;
          nxt.state     = hhp_pkg::S_METHOD;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_METHOD: begin
        if (c == hhp_pkg::CH_SP) begin
          if (cur.mcount == 3'd3 && cur.mchars[0] == hhp_pkg::CH_G &&
              cur.mchars[1] == hhp_pkg::CH_E && cur.mchars[2] == hhp_pkg::CH_T) begin
            nxt.mseen = hhp_pkg::METH_GET;
            nxt.state = hhp_pkg::S_WS_URI;
          end else if (cur.mcount == 3'd4 && cur.mchars[0] == hhp_pkg::CH_P &&
                       cur.mchars[1] == hhp_pkg::CH_O &&
                       cur.mchars[2] == hhp_pkg::CH_S &&
                       cur.mchars[3] == hhp_pkg::CH_T) begin
            nxt.mseen = hhp_pkg::METH_POST;
            nxt.state = hhp_pkg::S_WS_URI;
          end else begin
            fail = 1'b1;
          end
        end else if (cur.mcount >= 3'd4) begin
          fail = 1'b1;
        end else begin
          nxt.mchars[cur.mcount[1:0]] = c;
          nxt.mcount = 3'(cur.mcount + 3'd1);
          cls        = hhp_pkg::CLS_METHOD;
        end
      end
      hhp_pkg::S_WS_URI: begin
        if (c == hhp_pkg::CH_SLASH) begin
          nxt.uri_cnt = 16'd1;
          cls         = hhp_pkg::CLS_URI;
          nxt.state   = hhp_pkg::S_URI;
        end else if (c != hhp_pkg::CH_SP) begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_URI: begin
        if (cur.uri_cnt >= max_len_i || c == hhp_pkg::CH_NUL) begin
          fail = 1'b1;
        end else if (c == hhp_pkg::CH_SP) begin
          nxt.state = hhp_pkg::S_WS_PROTO;
        end else begin
          nxt.uri_cnt = 16'(cur.uri_cnt + 16'd1);
          cls         = hhp_pkg::CLS_URI;
        end
      end
      hhp_pkg::S_WS_PROTO: begin
        if (c == hhp_pkg::CH_H) begin
          nxt.state = hhp_pkg::S_P_H;
        end else if (c != hhp_pkg::CH_SP) begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_P_H: begin
        if (c == hhp_pkg::CH_T) nxt.state = hhp_pkg::S_P_HT;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_HT: begin
        if (c == hhp_pkg::CH_T) nxt.state = hhp_pkg::S_P_HTT;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_HTT: begin
        if (c == hhp_pkg::CH_P) nxt.state = hhp_pkg::S_P_HTTP;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_HTTP: begin
        if (c == hhp_pkg::CH_SLASH) nxt.state = hhp_pkg::S_P_SLASH;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_SLASH: begin
        if (c == hhp_pkg::CH_ONE) nxt.state = hhp_pkg::S_P_MAJOR;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_MAJOR: begin
        if (c == hhp_pkg::CH_DOT) nxt.state = hhp_pkg::S_P_DOT;
        else fail = 1'b1;
      end
      hhp_pkg::S_P_DOT: begin
        if (c == hhp_pkg::CH_ZERO) begin
          nxt.vseen = hhp_pkg::VER_1_0;
          nxt.state = hhp_pkg::S_LINE_CR;
        end else if (c == hhp_pkg::CH_ONE) begin
          nxt.vseen = hhp_pkg::VER_1_1;
          nxt.state = hhp_pkg::S_LINE_CR;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_LINE_CR: begin
        if (c == hhp_pkg::CH_LF) begin
          status    = hhp_pkg::STAT_LINE;
          nxt.state = hhp_pkg::S_HDR_START;
        end else if (c == hhp_pkg::CH_CR) begin
          nxt.state = hhp_pkg::S_LINE_LF;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_LINE_LF: begin
        if (c == hhp_pkg::CH_LF) begin
          status    = hhp_pkg::STAT_LINE;
          nxt.state = hhp_pkg::S_HDR_START;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_HDR_START: begin
        if (c == hhp_pkg::CH_CR) begin
          nxt.state = hhp_pkg::S_HDR_END_LF;
        end else if (c == hhp_pkg::CH_LF) begin
          status    = hhp_pkg::STAT_HDRS;
          nxt.state = hhp_pkg::S_HDR_DONE;
        end else if (hhp_pkg::is_name_char(c) && cur.name_cnt < max_len_i) begin
          nxt.name_cnt = 16'(cur.name_cnt + 16'd1);
          cls          = hhp_pkg::CLS_NAME;
          nxt.state    = hhp_pkg::S_HDR_NAME;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_HDR_END_LF: begin
        if (c == hhp_pkg::CH_LF) begin
          status    = hhp_pkg::STAT_HDRS;
          nxt.state = hhp_pkg::S_HDR_DONE;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_HDR_NAME: begin
        if (hhp_pkg::is_name_char(c)) begin
          if (cur.name_cnt >= max_len_i) begin
            fail = 1'b1;
          end else begin
            nxt.name_cnt = 16'(cur.name_cnt + 16'd1);
            cls          = hhp_pkg::CLS_NAME;
          end
        end else if (c == hhp_pkg::CH_COLON) begin
          nxt.state = hhp_pkg::S_HDR_PRE_VAL;
        end else if (c == hhp_pkg::CH_CR) begin
          line_done = 1'b1;
          nxt.state = hhp_pkg::S_HDR_LINE_LF;
        end else if (c == hhp_pkg::CH_LF) begin
          line_done = 1'b1;
          nxt.state = hhp_pkg::S_HDR_START;
        end else begin
          fail = 1'b1;
        end
      end
      hhp_pkg::S_HDR_PRE_VAL, hhp_pkg::S_HDR_VALUE: begin
        if (c == hhp_pkg::CH_CR) begin
          line_done = 1'b1;
          nxt.state = hhp_pkg::S_HDR_LINE_LF;
        end else if (c == hhp_pkg::CH_LF) begin
          line_done = 1'b1;
          nxt.state = hhp_pkg::S_HDR_START;
        end else if (blank && cur.state == hhp_pkg::S_HDR_PRE_VAL) begin
          // leading blank, skipped
        end else if (cur.value_cnt >= max_len_i) begin
          fail = 1'b1;
        end else begin
          nxt.value_cnt = 16'(cur.value_cnt + 16'd1);
          if (!blank) begin
            nxt.trim_cnt = nxt.value_cnt;
          end
          cls       = hhp_pkg::CLS_VALUE;
          nxt.state = hhp_pkg::S_HDR_VALUE;
        end
      end
      hhp_pkg::S_HDR_LINE_LF: begin
        if (c == hhp_pkg::CH_LF) nxt.state = hhp_pkg::S_HDR_START;
        else fail = 1'b1;
      end
      hhp_pkg::S_HDR_DONE: begin
        status = hhp_pkg::STAT_IGNORED;
      end
      default: begin
        // error state and unused codes
        fail = 1'b1;
      end
    endcase

    if (fail) begin
      nxt       = cur;
      nxt.state = hhp_pkg::S_ERROR;
      status    = hhp_pkg::STAT_ERROR;
      cls       = hhp_pkg::CLS_DELIM;
      line_done = 1'b0;
    end

    nlen = nxt.name_cnt;
    vlen = nxt.trim_cnt;
    if (line_done) begin
      commit        = (nxt.name_cnt != 16'd0);
      nxt.name_cnt  = 16'd0;
      nxt.value_cnt = 16'd0;
      nxt.trim_cnt  = 16'd0;
    end
  end

  assign ctx_o           = nxt;
  assign res_o.status    = status;
  assign res_o.cls       = cls;
  assign res_o.data      = c;
  assign res_o.method    = nxt.mseen;
  assign res_o.version   = nxt.vseen;
  assign res_o.uri_len   = nxt.uri_cnt;
  assign res_o.commit    = commit;
  assign res_o.name_len  = nlen;
  assign res_o.value_len = vlen;

endmodule
`default_nettype wire

### rtl/http_request_head_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted input transaction is held in the input register and moves on to
// the result register (out_valid) once that register is free or being emptied.
// Throughput: 1 byte per cycle while the output is not stalled; the parser
// context register closes its loop through one step of logic for each byte.
// Reset (rst_n low, synchronous): pipeline empty, parser at request start,
// max_field_length back to 1024.
// ----------------------------------------------------------------------------
// http_request_head_parser: byte-serial HTTP request head parser
// Input register -> parse step -> result register, with the parser context
// held in registers that advance together with the result register.
// ----------------------------------------------------------------------------
module http_request_head_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_new_request,
  // per-byte result
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [2:0]       out_byte_class,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_method_code,
  output logic [1:0]       out_version_code,
  output logic [15:0]      out_uri_length,
  output logic             out_header_commit,
  output logic [15:0]      out_name_length,
  output logic [15:0]      out_value_length,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  hhp_pkg::item_t in_item;
  hhp_pkg::item_t s1_item;
  logic           s1_valid;
  logic           advance;

  hhp_pkg::ctx_t  ctx_r;
  hhp_pkg::ctx_t  ctx_nxt;
  hhp_pkg::ctx_t  step_ctx;
  hhp_pkg::res_t  step_res;
  hhp_pkg::res_t  res_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic [15:0]    max_len;

  // field length limit register
  hhp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // The held byte moves on whenever the result register is free or is
  // being emptied this cycle; the input register refills in the same edge.
  assign advance = s1_valid && (!out_valid_r || !out_stall);

  assign in_item.new_req = in_new_request;
  assign in_item.data    = in_byte;

  hhp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_i   (in_item),
    .take_i   (advance),
    .valid_o  (s1_valid),
    .item_o   (s1_item)
  );

  // single-byte parse step (new_request clear is folded in)
  hhp_step u_step (
    .ctx_i     (ctx_r),
    .item_i    (s1_item),
    .max_len_i (max_len),
    .ctx_o     (step_ctx),
    .res_o     (step_res)
  );

  always_comb begin
    ctx_nxt       = ctx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      ctx_nxt       = step_ctx;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= hhp_pkg::CTX_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: loaded only when a new transaction lands
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_byte_class    = res_r.cls;
  assign out_byte          = res_r.data;
  assign out_method_code   = res_r.method;
  assign out_version_code  = res_r.version;
  assign out_uri_length    = res_r.uri_len;
  assign out_header_commit = res_r.commit;
  assign out_name_length   = res_r.name_len;
  assign out_value_length  = res_r.value_len;

endmodule
`default_nettype wire
